// ----- hw/rtl/rgb_to_grey_sobel_edge_stream_macros.svh -----
// ----------------------------------------------------------------------------
// rgb_to_grey_sobel_edge_stream_macros
// Assertion macros used by the checker of the edge stream block.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_GREY_SOBEL_EDGE_STREAM_MACROS_SVH
`define RGB_TO_GREY_SOBEL_EDGE_STREAM_MACROS_SVH

// Same-cycle implication, held off while in reset
`define RGSE_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset
`define RGSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rgse_pkg.sv -----
// ----------------------------------------------------------------------------
// rgse_pkg
// Types, constants and helpers of the RGB-to-grey Sobel edge stream.
// ----------------------------------------------------------------------------
package rgse_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 4;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // reset frame geometry
    localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = CFG_W'(480);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Q8 luma weights (0.299, 0.587, 0.114)
    localparam int GREY_WR = 77;
    localparam int GREY_WG = 150;
    localparam int GREY_WB = 29;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             position_valid;
        logic             frame_last;
    } edge_out_t;

    // 3x3 window less the centre tap
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tc;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] ml;
        logic [PIX_W-1:0] mr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] bc;
        logic [PIX_W-1:0] br;
    } sobel_taps_t;

    // per-word flags carried alongside the memory read
    typedef struct packed {
        logic pos_valid;
        logic edge_en;
        logic last;
    } stage_ctl_t;

    // weighted sum, truncated to 8 bits
    function automatic logic [PIX_W-1:0] rgb_to_grey(pixel_in_t px);
        logic [2*PIX_W-1:0] acc;
        acc = (2*PIX_W)'(GREY_WR * int'(px.red) + GREY_WG * int'(px.green)
                         + GREY_WB * int'(px.blue));
        return acc[2*PIX_W-1:PIX_W];
    endfunction

endpackage

// ----- hw/rtl/rgse_ram.sv -----
// ----------------------------------------------------------------------------
// rgse_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rgse_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rgse_sobel.sv -----
// ----------------------------------------------------------------------------
// rgse_sobel
// Sobel gradient magnitude |Gx|+|Gy| over a 3x3 window, saturated to 8 bits.
// ----------------------------------------------------------------------------
module rgse_sobel (
    input  rgse_pkg::sobel_taps_t  taps,
    output logic [rgse_pkg::PIX_W-1:0] mag
);
    import rgse_pkg::*;

    localparam int SUM_W = PIX_W + 2;

    logic [SUM_W-1:0] xp, xn, yp, yn;
    logic [SUM_W-1:0] dx, dy;
    logic [SUM_W:0]   total;

    // weighted column and row sums (1,2,1)
    assign xp = SUM_W'(taps.tr) + {1'b0, taps.mr, 1'b0} + SUM_W'(taps.br);
    assign xn = SUM_W'(taps.tl) + {1'b0, taps.ml, 1'b0} + SUM_W'(taps.bl);
    assign yp = SUM_W'(taps.tl) + {1'b0, taps.tc, 1'b0} + SUM_W'(taps.tr);
    assign yn = SUM_W'(taps.bl) + {1'b0, taps.bc, 1'b0} + SUM_W'(taps.br);

    // absolute differences
    assign dx = (xp >= xn) ? xp - xn : xn - xp;
    assign dy = (yp >= yn) ? yp - yn : yn - yp;

    // magnitude with saturation
    assign total = {1'b0, dx} + {1'b0, dy};
    assign mag   = (total > (SUM_W+1)'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : total[PIX_W-1:0];

endmodule

// ----- hw/rtl/rgb_to_grey_sobel_edge_stream.sv -----
// ----------------------------------------------------------------------------
// rgb_to_grey_sobel_edge_stream
// Raster RGB pixels in, saturated Sobel edge magnitude of the grey image out.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the output is not stalled and returns
// one result word per pixel, for the position one row up and one column
// left; border positions give 0 and position_valid flags whether that
// position lies inside the frame. A taken word first reads both grey line
// stores at the current column; when it advances, the window shifts, the
// line stores are written back and the result is registered. Each line store
// has one read and one write port, and a frame width of at least three keeps
// any column from being read before its last write lands. frame_width and
// frame_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; write them
// only while no word is in flight.
// ----------------------------------------------------------------------------
module rgb_to_grey_sobel_edge_stream #(
    parameter int MAX_WIDTH  = rgse_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgse_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rgse_pkg::pixel_in_t             s_data,
    // edge output
    output logic                            m_valid,
    input  logic                            m_ready,
    output rgse_pkg::edge_out_t             m_data,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgse_pkg::CFG_W-1:0]      cfg_data
);
    import rgse_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int LIMW = CFG_W + 2;

    // configuration
    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic          col_end, row_end;

    // read stage
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_grey_reg, s1_grey_next;
    logic [CW-1:0]    s1_col_reg, s1_col_next;
    stage_ctl_t       s1_ctl_reg, s1_ctl_next;

    // window columns: a = left, b = centre, fresh column comes from memory
    logic [PIX_W-1:0] win_a_reg [3];
    logic [PIX_W-1:0] win_a_next [3];
    logic [PIX_W-1:0] win_b_reg [3];
    logic [PIX_W-1:0] win_b_next [3];

    // output register
    logic      out_valid_reg, out_valid_next;
    edge_out_t out_data_reg, out_data_next;

    logic             s_accept, s1_adv;
    logic [PIX_W-1:0] upper_rd, middle_rd;
    logic [PIX_W-1:0] mag;
    sobel_taps_t      taps;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // register writes
    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // clamped last column / last row
    always_comb begin
        if (frame_width_reg < CFG_W'(3)) begin
            w_last = CW'(2);
        end else if (LIMW'(frame_width_reg) > LIMW'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(frame_width_reg - CFG_W'(1));
        end
        if (frame_height_reg < CFG_W'(3)) begin
            h_last = RW'(2);
        end else if (LIMW'(frame_height_reg) > LIMW'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(frame_height_reg - CFG_W'(1));
        end
    end

    assign col_end = col_reg >= w_last;
    assign row_end = row_reg >= h_last;

    // raster position and read-stage capture
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        s1_grey_next  = s1_grey_reg;
        s1_col_next   = s1_col_reg;
        s1_ctl_next   = s1_ctl_reg;
        s1_valid_next = s1_adv ? 1'b0 : s1_valid_reg;
        if (s_accept) begin
            s1_valid_next         = 1'b1;
            s1_grey_next          = rgb_to_grey(s_data);
            s1_col_next           = col_reg;
            s1_ctl_next.pos_valid = (row_reg != '0) && (col_reg != '0);
            s1_ctl_next.edge_en   = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
            s1_ctl_next.last      = row_end && col_end;
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // window shift on advance
    always_comb begin
        win_a_next = win_a_reg;
        win_b_next = win_b_reg;
        if (s1_adv) begin
            win_a_next    = win_b_reg;
            win_b_next[0] = upper_rd;
            win_b_next[1] = middle_rd;
            win_b_next[2] = s1_grey_reg;
        end
    end

    // window taps: registered left and centre columns plus the fresh column
    always_comb begin
        taps.tl = win_a_reg[0];
        taps.tc = win_b_reg[0];
        taps.tr = upper_rd;
        taps.ml = win_a_reg[1];
        taps.mr = middle_rd;
        taps.bl = win_a_reg[2];
        taps.bc = win_b_reg[2];
        taps.br = s1_grey_reg;
    end

    rgse_sobel u_sobel (
        .taps (taps),
        .mag  (mag)
    );

    // output register
    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        if (s1_adv) begin
            out_valid_next               = 1'b1;
            out_data_next.edge_res       = s1_ctl_reg.edge_en ? mag : '0;
            out_data_next.position_valid = s1_ctl_reg.pos_valid;
            out_data_next.frame_last     = s1_ctl_reg.last;
        end
    end

    // line stores: read on accept, write back on advance
    rgse_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_upper (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (middle_rd),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (upper_rd)
    );

    rgse_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_middle (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_grey_reg),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (middle_rd)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DEF_FRAME_WIDTH;
            frame_height_reg <= DEF_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                win_a_reg[k] <= '0;
                win_b_reg[k] <= '0;
            end
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            win_a_reg        <= win_a_next;
            win_b_reg        <= win_b_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        s1_grey_reg  <= s1_grey_next;
        s1_col_reg   <= s1_col_next;
        s1_ctl_reg   <= s1_ctl_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- hw/rtl/rgse_checker.sv -----
// ----------------------------------------------------------------------------
// rgse_checker
// Port-level checks of the edge stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_grey_sobel_edge_stream_macros.svh"

module rgse_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rgse_pkg::edge_out_t m_data
);
    import rgse_pkg::*;

    // a stalled result word holds
    `RGSE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // outside the frame the magnitude is zero
    `RGSE_ASSERT_IMPLIES(a_border_zero, aclk, aresetn, m_valid && !m_data.position_valid, m_data.edge_res == '0, "non-zero edge outside frame")

    // the closing pixel always maps inside the frame
    `RGSE_ASSERT_IMPLIES(a_last_inside, aclk, aresetn, m_valid && m_data.frame_last, m_data.position_valid, "frame end on an invalid position")

    // input only back-pressured by a full, stalled output
    `RGSE_ASSERT_IMPLIES(a_ready_cause, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output stall")

endmodule

bind rgb_to_grey_sobel_edge_stream rgse_checker u_rgse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/tb_rgb_to_grey_sobel_edge_stream.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_to_grey_sobel_edge_stream
// Self-checking testbench for the RGB-to-grey Sobel edge stream.
// ----------------------------------------------------------------------------
// Raster pixel words are pushed through the valid/ready input while a local
// model of the grey conversion, line stores, 3x3 window and Sobel magnitude
// predicts every result word. Results are sampled on the falling edge and
// compared field by field, in order. Covered: the reset line width, extreme
// colours, the smallest frame, unmapped register indexes, sizes clamped from
// both sides, resizing mid-frame, a long output hold-off and random frames
// under three idling mixes.
// ----------------------------------------------------------------------------
module tb_rgb_to_grey_sobel_edge_stream;

    timeunit 1ns;
    timeprecision 1ps;

    import rgse_pkg::*;

    localparam int unsigned LINE_MAX     = DEF_MAX_WIDTH;
    localparam int unsigned ROWS_MAX     = DEF_MAX_HEIGHT;
    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned EDGE_MAX     = 255;
    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned DRAIN_SETTLE = 4;
    localparam int unsigned END_SETTLE   = 8;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned RANDOM_ITEMS = 960;
    localparam int          WIDE_PART    = 24;
    localparam int          NO_LIMIT     = -1;

    // register indexes past the end of the map
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_FRAME_HEIGHT + 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    // colour mix of a random frame
    typedef enum logic [1:0] {
        TONE_UNIFORM,
        TONE_SATURATED,
        TONE_FLAT
    } tone_t;

    // clock, reset and block ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    pixel_in_t            s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    edge_out_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // stimulus control
    int unsigned src_idle_pct  = 25;
    int unsigned sink_idle_pct = 57;
    int unsigned hold_asked    = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    pixel_in_t   flat_base     = '0;

    // expected result words, oldest first
    edge_out_t   edge_expected [$];

    // run statistics
    int unsigned errors        = 0;
    int unsigned pixels_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_seen   = 0;
    int unsigned input_stalls  = 0;

    // local model of the block
    logic [CFG_W-1:0] width_reg  = DEF_FRAME_WIDTH;
    logic [CFG_W-1:0] height_reg = DEF_FRAME_HEIGHT;
    logic [PIX_W-1:0] upper_line  [LINE_MAX];
    logic [PIX_W-1:0] middle_line [LINE_MAX];
    logic [PIX_W-1:0] win [9]     = '{default: '0};
    int unsigned      col_pos     = 0;
    int unsigned      row_pos     = 0;

    rgb_to_grey_sobel_edge_stream dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        return (v > hi) ? hi : v;
    endfunction

    // grey, window shift, line store update and Sobel magnitude of one pixel
    function automatic edge_out_t predict_edge(pixel_in_t px);
        int unsigned      w, h, slot, k;
        int unsigned      gx_pos, gx_neg, gy_pos, gy_neg, mag;
        logic [PIX_W-1:0] grey, top_px, mid_px;
        edge_out_t        res;
        w    = clamp_dim(width_reg, LINE_MAX);
        h    = clamp_dim(height_reg, ROWS_MAX);
        slot = (col_pos < LINE_MAX) ? col_pos : LINE_MAX - 1;
        grey = PIX_W'((GREY_WR * int'(px.red) + GREY_WG * int'(px.green)
                       + GREY_WB * int'(px.blue)) >> PIX_W);
        top_px = upper_line[slot];
        mid_px = middle_line[slot];
        for (k = 0; k < 3; k++) begin
            win[3*k]     = win[3*k + 1];
            win[3*k + 1] = win[3*k + 2];
        end
        win[2] = top_px;
        win[5] = mid_px;
        win[8] = grey;
        upper_line[slot]  = mid_px;
        middle_line[slot] = grey;

        res = '0;
        res.position_valid = (row_pos >= 1) && (col_pos >= 1);
        // full kernels only once two rows and two columns are in the window
        if (row_pos >= 2 && col_pos >= 2) begin
            gx_pos = win[2] + 2 * win[5] + win[8];
            gx_neg = win[0] + 2 * win[3] + win[6];
            gy_pos = win[0] + 2 * win[1] + win[2];
            gy_neg = win[6] + 2 * win[7] + win[8];
            mag = ((gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos)
                + ((gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos);
            res.edge_res = (mag > EDGE_MAX) ? PIX_W'(EDGE_MAX) : PIX_W'(mag);
        end
        res.frame_last = (row_pos >= h - 1) && (col_pos >= w - 1);

        // raster counters; a column or row at or past the end wraps
        if (col_pos >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    function automatic pixel_in_t rand_pixel(tone_t tone);
        pixel_in_t px;
        px = (3 * PIX_W)'($urandom);
        case (tone)
            TONE_SATURATED: begin
                px.red   = {PIX_W{px.red[0]}};
                px.green = {PIX_W{px.green[0]}};
                px.blue  = {PIX_W{px.blue[0]}};
            end
            TONE_FLAT: begin
                // near-constant image, small gradients only
                px = flat_base ^ {{(2*PIX_W){1'b0}}, 6'b0, px.blue[1:0]};
            end
            default: ;
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // offer one pixel word, record its expected result once accepted
    task automatic send_pixel(input pixel_in_t px, output bit at_frame_end);
        edge_out_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        res = predict_edge(px);
        edge_expected.push_back(res);
        at_frame_end = res.frame_last;
        pixels_sent++;
    endtask

    // send until the frame ends or limit words have gone
    task automatic send_frame_part(input tone_t tone, input int limit);
        bit done;
        int n;
        done = 1'b0;
        n    = 0;
        while (!done && n != limit) begin
            send_pixel(rand_pixel(tone), done);
            n++;
        end
    endtask

    // stop offering and wait until every expected word has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (edge_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = val;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = val;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // result sink: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: sampled mid-cycle, ahead of the edge that moves the word
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        edge_out_t want;
        if (aresetn) begin
            if (s_valid && !s_ready)
                input_stalls++;
            if (m_valid && m_ready) begin
                results_seen++;
                if (edge_expected.size() == 0) begin
                    errors++;
                    $display("%0t: result word %0h arrived with none expected",
                             $time, m_data);
                end else begin
                    want = edge_expected.pop_front();
                    if (want.frame_last)
                        frames_seen++;
                    if (m_data.edge_res !== want.edge_res) begin
                        errors++;
                        $display("%0t: edge_res expected %0d actual %0d",
                                 $time, want.edge_res, m_data.edge_res);
                    end
                    if (m_data.position_valid !== want.position_valid) begin
                        errors++;
                        $display("%0t: position_valid expected %0b actual %0b",
                                 $time, want.position_valid, m_data.position_valid);
                    end
                    if (m_data.frame_last !== want.frame_last) begin
                        errors++;
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, want.frame_last, m_data.frame_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // 640 wide out of reset; pause early in row 1, then cut the frame to 6x3
    task automatic test_reset_geometry();
        send_frame_part(TONE_UNIFORM, DEF_FRAME_WIDTH + 5);
        set_geometry(CFG_W'(6), CFG_W'(2));
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
    endtask

    // colour cube corners on a 4x4 frame, then a grey ramp on the 3x3 minimum
    task automatic test_directed_pixels();
        pixel_in_t corners [16];
        pixel_in_t px;
        bit        done;
        int        r, c;
        corners = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                    24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
                    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F};
        set_geometry(CFG_W'(4), CFG_W'(4));
        foreach (corners[i])
            send_pixel(corners[i], done);
        set_geometry(CFG_W'(MIN_DIM), CFG_W'(MIN_DIM));
        for (r = 0; r < MIN_DIM; r++) begin
            for (c = 0; c < MIN_DIM; c++) begin
                px.red   = PIX_W'(10 + 10 * c + 3 * r);
                px.green = px.red;
                px.blue  = px.red;
                send_pixel(px, done);
            end
        end
    endtask

    // writes to indexes past the map must leave the geometry alone
    task automatic test_unmapped_registers();
        set_geometry(CFG_W'(5), CFG_W'(MIN_DIM));
        write_reg(REG_SPARE_FIRST, {CFG_W{1'b1}});
        write_reg(REG_SPARE_LAST, '0);
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
    endtask

    // shrink the width, then the height, with the counters already past them
    task automatic test_shrink_mid_frame();
        set_geometry(CFG_W'(16), CFG_W'(10));
        send_frame_part(TONE_UNIFORM, 5 * 16 + 10);
        write_reg(REG_FRAME_WIDTH, CFG_W'(4));
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
        set_geometry(CFG_W'(8), CFG_W'(12));
        send_frame_part(TONE_UNIFORM, 7 * 8 + 3);
        write_reg(REG_FRAME_HEIGHT, CFG_W'(5));
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
    endtask

    // sink held off while the source keeps offering; the block must stall
    task automatic test_output_hold_off();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_geometry(CFG_W'(6), CFG_W'(5));
        hold_asked <= hold_asked + 1;
        send_frame_part(TONE_SATURATED, NO_LIMIT);
        wait_idle();
    endtask

    // sizes clamped from below, then from above with the frame cut short
    task automatic test_clamped_sizes();
        src_idle_pct  = 10;
        sink_idle_pct = 20;
        set_geometry(CFG_W'(2), '0);
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
        set_geometry({CFG_W{1'b1}}, {CFG_W{1'b1}});
        send_frame_part(TONE_SATURATED, WIDE_PART);
        set_geometry(CFG_W'(5), CFG_W'(MIN_DIM));
        send_frame_part(TONE_UNIFORM, NO_LIMIT);
    endtask

    // small random frames, mostly back to back, under three idling mixes
    task automatic test_random_frames();
        int unsigned phase, goal, w, h, pause_at;
        tone_t       tone;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 25; sink_idle_pct = 57; end
                1:       begin src_idle_pct = 57; sink_idle_pct = 25; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            goal = pixels_sent + RANDOM_ITEMS / 3;
            while (pixels_sent < goal) begin
                if ($urandom_range(2) == 0) begin
                    w = ($urandom_range(9) == 0) ? $urandom_range(13, 64)
                                                 : $urandom_range(MIN_DIM, 12);
                    h = $urandom_range(MIN_DIM, 8);
                    // now and then a size below the minimum
                    if ($urandom_range(15) == 0) w = $urandom_range(MIN_DIM - 1);
                    if ($urandom_range(15) == 0) h = $urandom_range(MIN_DIM - 1);
                    set_geometry(CFG_W'(w), CFG_W'(h));
                end
                if ($urandom_range(19) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                              CFG_W'($urandom));
                tone      = tone_t'($urandom_range(TONE_FLAT));
                flat_base = (3 * PIX_W)'($urandom);
                // occasionally stop mid-frame until the block has drained
                if ($urandom_range(7) == 0) begin
                    pause_at = $urandom_range(1, clamp_dim(width_reg, LINE_MAX)
                                                 * clamp_dim(height_reg, ROWS_MAX) - 1);
                    send_frame_part(tone, pause_at);
                    wait_idle();
                end
                send_frame_part(tone, NO_LIMIT);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_geometry();
        test_directed_pixels();
        test_unmapped_registers();
        test_shrink_mid_frame();
        test_output_hold_off();
        test_clamped_sizes();
        test_random_frames();

        wait_idle();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Sent %0d pixel words, checked %0d results across %0d frames,",
                 pixels_sent, results_seen, frames_seen);
        $display("reset, clamped, unmapped and mid-frame geometry; input stalled on %0d cycles",
                 input_stalls);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
